// ===== rtl/sit_pkg.sv =====
package sit_pkg;

  localparam int MODE_W = 2;
  localparam int SLOT_W = 6;
  localparam int TIME_W = 63;
  localparam int SMP_W  = 64;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 7;

  localparam int IN_FIELDS_W  = SLOT_W + TIME_W + SMP_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 5 * TIME_W + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ILLEGAL = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NEG     = 2'd2;

  localparam logic [CFG_W-1:0]  ACTIVE_RST = 7'd64;
  localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] min;
    logic [TIME_W-1:0] max;
    logic [TIME_W-1:0] sum;
    logic [CNT_W-1:0]  cnt;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    start: '0,
    min:   TIME_MAX,
    max:   '0,
    sum:   '0,
    cnt:   '0
  };

endpackage

// ===== rtl/sit_div.sv =====
module sit_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sit_pkg::TIME_W-1:0] dividend,
  input  logic [sit_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [sit_pkg::TIME_W-1:0] quotient
);
  import sit_pkg::*;

  localparam int STEP_W = $clog2(TIME_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // restoring division, one quotient bit per cycle, msb first
  assign trial = {rem_r, quo_r[TIME_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(TIME_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[TIME_W-2:0], ge};
      rem_nxt  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/slot_interval_statistics_unit.sv =====
// Slot interval statistics. Each of SLOTS slots keeps a start stamp and the
// min, max, saturating sum and saturating count of its durations in one
// single-port-read, single-port-write memory. Input tuser carries the mode
// (start, stop, add sample); every request yields one result whose tuser is
// the status and whose tdata holds the interval, count, min, max, sum and the
// truncated mean. One request is in flight at a time: a legal slot passes
// through read, interval, write back, the bit-serial mean divider and then the
// output register; a slot whose count stays zero skips the divider, and an
// illegal slot goes straight to the output register. After reset the memory is
// cleared one entry a cycle, and in_tready stays low until the clear is done.
// The active_slots register lies at byte address 0 of the APB port.
module slot_interval_statistics_unit #(
  parameter int SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // slot, timestamp_ns, sample_ns (lsb first), zero padded
  input  logic [sit_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic [sit_pkg::MODE_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // interval_ns, count, min_ns, max_ns, sum_ns, mean_ns (lsb first), zero padded
  output logic [sit_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [sit_pkg::STAT_W-1:0]     out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);
  import sit_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]        st_r, st_nxt;
  logic [AW-1:0]     clr_r;
  logic [CFG_W-1:0]  active_r;

  logic [MODE_W-1:0] mode_r;
  logic [AW-1:0]     slot_r;
  logic [TIME_W-1:0] ts_r;
  logic [SMP_W-1:0]  smp_r;
  logic              illegal_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              acc_r, acc_nxt;
  logic [TIME_W-1:0] interval_r, interval_nxt;
  entry_t            ent_r, ent_nxt;
  logic              mean_sel_r;

  logic [SLOT_W-1:0] in_slot;
  logic [TIME_W-1:0] in_ts;
  logic [SMP_W-1:0]  in_smp;
  logic              in_req;
  logic              in_legal;

  entry_t            mem [SLOTS];
  entry_t            rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  entry_t            mem_wd;

  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] div_quo;
  logic [TIME_W:0]   sum_wide;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [STAT_W-1:0]     out_tuser_r;
  logic                  out_load;
  logic [TIME_W-1:0]     mean;
  logic                  cfg_wr;

  assign in_slot = in_tdata[SLOT_W-1:0];
  assign in_ts   = in_tdata[SLOT_W+TIME_W-1:SLOT_W];
  assign in_smp  = in_tdata[SLOT_W+TIME_W+SMP_W-1:SLOT_W+TIME_W];

  assign in_tready = (st_r == ST_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign in_legal  = ({1'b0, in_slot} < active_r) && (int'(in_slot) < SLOTS);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32 - CFG_W){1'b0}}, active_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else if (cfg_wr) begin
      active_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  // interval of this request: for a stop, from the entry read back; for an add, the sample
  always_comb begin
    interval_nxt = '0;
    acc_nxt      = 1'b0;
    status_nxt   = STATUS_OK;
    case (mode_r)
      MODE_STOP: begin
        interval_nxt = ts_r - rd_data_r.start;
        acc_nxt      = 1'b1;
      end
      MODE_ADD: begin
        if (smp_r[SMP_W-1]) begin
          status_nxt = STATUS_NEG;
        end else begin
          interval_nxt = smp_r[TIME_W-1:0];
          acc_nxt      = 1'b1;
        end
      end
      default: begin
        interval_nxt = '0;
      end
    endcase
  end

  // updated entry
  assign sum_wide = {1'b0, rd_data_r.sum} + {1'b0, interval_r};

  always_comb begin
    ent_nxt = rd_data_r;
    if (mode_r == MODE_START) begin
      ent_nxt.start = ts_r;
    end
    if (acc_r) begin
      if (rd_data_r.max <= interval_r) begin
        ent_nxt.max = interval_r;
      end
      if (rd_data_r.min >= interval_r) begin
        ent_nxt.min = interval_r;
      end
      if (rd_data_r.cnt != CNT_MAX) begin
        ent_nxt.cnt = rd_data_r.cnt + 1'b1;
      end
      ent_nxt.sum = sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];
    end
  end

  assign mem_we    = (st_r == ST_CLEAR) || (st_r == ST_UPD);
  assign mem_wa    = (st_r == ST_CLEAR) ? clr_r : slot_r;
  assign mem_wd    = (st_r == ST_CLEAR) ? ENTRY_RST : ent_nxt;
  assign div_start = (st_r == ST_UPD) && (ent_nxt.cnt != '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_req) begin
      rd_data_r <= mem[AW'(in_slot)];
    end
  end

  sit_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ent_nxt.sum),
    .divisor  (ent_nxt.cnt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_load = (st_r == ST_OUT) && (!out_tvalid_r || out_tready);
  assign mean     = mean_sel_r ? div_quo : '0;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (clr_r == AW'(SLOTS - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_req) begin
          st_nxt = in_legal ? ST_READ : ST_OUT;
        end
      end
      ST_READ: st_nxt = ST_UPD;
      ST_UPD:  st_nxt = div_start ? ST_DIV : ST_OUT;
      ST_DIV: begin
        if (div_done) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLEAR;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      mode_r    <= in_tuser;
      slot_r    <= AW'(in_slot);
      ts_r      <= in_ts;
      smp_r     <= in_smp;
      illegal_r <= !in_legal;
    end
    if (st_r == ST_READ) begin
      interval_r <= interval_nxt;
      acc_r      <= acc_nxt;
      status_r   <= status_nxt;
    end
    if (st_r == ST_UPD) begin
      ent_r      <= ent_nxt;
      mean_sel_r <= div_start;
    end
    if (out_load) begin
      if (illegal_r) begin
        out_tdata_r <= '0;
        out_tuser_r <= STATUS_ILLEGAL;
      end else begin
        out_tdata_r <= OUT_DATA_W'({mean, ent_r.sum, ent_r.max, ent_r.min, ent_r.cnt,
                                    interval_r});
        out_tuser_r <= status_r;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // one request in flight: the port closes right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_ILLEGAL) |-> (out_tdata == '0))
    else $error("illegal slot result carries statistics");

  a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[TIME_W+CNT_W-1:TIME_W] == '0)
      |-> (out_tdata[5*TIME_W+CNT_W-1:4*TIME_W+CNT_W] == '0))
    else $error("nonzero mean for an empty slot");

  a_div_idle_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !in_tready && mem_we)
    else $error("request taken during memory clear");
`endif

endmodule

// ===== verif/sit_stats_checker.sv =====
module sit_stats_checker #(
  parameter int SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // slot, timestamp_ns, sample_ns (lsb first), zero padded
  input  logic [sit_pkg::IN_DATA_W-1:0]  in_tdata,
  // mode
  input  logic [sit_pkg::MODE_W-1:0]     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // interval_ns, count, min_ns, max_ns, sum_ns, mean_ns (lsb first), zero padded
  input  logic [sit_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  input  logic [sit_pkg::STAT_W-1:0]     out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  input  logic [31:0]                    cfg_prdata,
  input  logic                           cfg_pready,
  output int                             fail_count,
  output int                             pending_cnt,
  output int                             results_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  localparam logic [2:0] ACTIVE_ADDR = 3'd0;

  localparam int TS_LSB   = SLOT_W;
  localparam int SMP_LSB  = SLOT_W + TIME_W;
  localparam int CNT_LSB  = TIME_W;
  localparam int MIN_LSB  = TIME_W + CNT_W;
  localparam int MAX_LSB  = 2 * TIME_W + CNT_W;
  localparam int SUM_LSB  = 3 * TIME_W + CNT_W;
  localparam int MEAN_LSB = 4 * TIME_W + CNT_W;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TIME_W-1:0] interval;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] lo_ns;
    logic [TIME_W-1:0] hi_ns;
    logic [TIME_W-1:0] sum_ns;
    logic [TIME_W-1:0] mean_ns;
  } slot_stats_t;

  logic [TIME_W-1:0] stamp_tbl [SLOTS];
  logic [TIME_W-1:0] lo_tbl    [SLOTS];
  logic [TIME_W-1:0] hi_tbl    [SLOTS];
  logic [TIME_W-1:0] sum_tbl   [SLOTS];
  logic [CNT_W-1:0]  cnt_tbl   [SLOTS];
  logic [CFG_W-1:0]  active_q;

  slot_stats_t expected_stats_q[$];

  function automatic void fold_duration(input int idx, input logic [TIME_W-1:0] dur);
    if (hi_tbl[idx] <= dur) hi_tbl[idx] = dur;
    if (lo_tbl[idx] >= dur) lo_tbl[idx] = dur;
    if (cnt_tbl[idx] != CNT_MAX) cnt_tbl[idx] = cnt_tbl[idx] + 1'b1;
    // saturate at the top of the 63-bit range
    if (dur > TIME_MAX - sum_tbl[idx]) sum_tbl[idx] = TIME_MAX;
    else sum_tbl[idx] = sum_tbl[idx] + dur;
  endfunction

  function automatic slot_stats_t predict_stats(input logic [MODE_W-1:0] mode,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [TIME_W-1:0] stamp,
                                                input logic [SMP_W-1:0]  sample);
    slot_stats_t r;
    int idx;
    r = '0;
    idx = int'(slot);
    if ({1'b0, slot} >= active_q || idx >= SLOTS) begin
      r.status = STATUS_ILLEGAL;
      return r;
    end
    r.status = STATUS_OK;
    case (mode)
      MODE_START: stamp_tbl[idx] = stamp;
      MODE_STOP: begin
        r.interval = stamp - stamp_tbl[idx];
        fold_duration(idx, r.interval);
      end
      MODE_ADD: begin
        if (sample[SMP_W-1]) begin
          r.status = STATUS_NEG;
        end else begin
          r.interval = sample[TIME_W-1:0];
          fold_duration(idx, r.interval);
        end
      end
      default: ;
    endcase
    r.count  = cnt_tbl[idx];
    r.lo_ns  = lo_tbl[idx];
    r.hi_ns  = hi_tbl[idx];
    r.sum_ns = sum_tbl[idx];
    r.mean_ns = (cnt_tbl[idx] != '0) ? sum_tbl[idx] / {31'd0, cnt_tbl[idx]} : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s expected %0h got %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending_cnt = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    slot_stats_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        stamp_tbl[i] = ENTRY_RST.start;
        lo_tbl[i]    = ENTRY_RST.min;
        hi_tbl[i]    = ENTRY_RST.max;
        sum_tbl[i]   = ENTRY_RST.sum;
        cnt_tbl[i]   = ENTRY_RST.cnt;
      end
      active_q = ACTIVE_RST;
      expected_stats_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == ACTIVE_ADDR) begin
        if (cfg_pwrite) begin
          active_q = cfg_pwdata[CFG_W-1:0];
        end else if (cfg_prdata !== {{(32-CFG_W){1'b0}}, active_q}) begin
          $error("active_slots readback expected %0h got %0h", active_q, cfg_prdata);
          fail_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        expected_stats_q.push_back(predict_stats(in_tuser, in_tdata[SLOT_W-1:0],
                                                 in_tdata[TS_LSB +: TIME_W],
                                                 in_tdata[SMP_LSB +: SMP_W]));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_stats_q.size() == 0) begin
          $error("result with no request outstanding, status %0h", out_tuser);
          fail_count++;
        end else begin
          want = expected_stats_q.pop_front();
          check_field("status", want.status, out_tuser);
          check_field("interval_ns", want.interval, out_tdata[0 +: TIME_W]);
          check_field("count", want.count, out_tdata[CNT_LSB +: CNT_W]);
          check_field("min_ns", want.lo_ns, out_tdata[MIN_LSB +: TIME_W]);
          check_field("max_ns", want.hi_ns, out_tdata[MAX_LSB +: TIME_W]);
          check_field("sum_ns", want.sum_ns, out_tdata[SUM_LSB +: TIME_W]);
          check_field("mean_ns", want.mean_ns, out_tdata[MEAN_LSB +: TIME_W]);
        end
      end
    end
    pending_cnt = expected_stats_q.size();
  end

endmodule

// ===== verif/slot_interval_statistics_unit_tb.sv =====
module slot_interval_statistics_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sit_pkg::*;

  localparam int         SLOTS       = 64;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [2:0] ACTIVE_ADDR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [2:0]            cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  int fail_count;
  int pending_cnt;
  int results_seen;
  int sent_cnt;
  int settings_cnt;

  bit idle_on;
  bit hold_off_req;
  logic [TIME_W-1:0] now_ns;

  slot_interval_statistics_unit #(.SLOTS(SLOTS)) uut (.*);

  sit_stats_checker #(.SLOTS(SLOTS)) stats_chk (.*);

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("slot_interval_statistics_unit_tb failed");
    $finish;
  end

  // result side: random ready bursts, one long hold-off on request
  initial begin : sink
    int len;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        len = 300;
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        len = $urandom_range(1, 18);
      end else begin
        out_tready <= 1'b1;
        len = $urandom_range(1, 30);
      end
      repeat (len) @(posedge clk);
    end
  end

  function automatic logic [TIME_W-1:0] rand63();
    return TIME_W'({$urandom, $urandom});
  endfunction

  task automatic send_req(input logic [MODE_W-1:0] m, input logic [SLOT_W-1:0] s,
                          input logic [TIME_W-1:0] ts, input logic [SMP_W-1:0] smp);
    in_tuser  <= m;
    in_tdata  <= {{(IN_DATA_W-IN_FIELDS_W){1'b0}}, smp, ts, s};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic random_req(input int span);
    logic [MODE_W-1:0] m;
    logic [SLOT_W-1:0] s;
    logic [TIME_W-1:0] ts;
    logic [TIME_W-1:0] step;
    logic [SMP_W-1:0]  smp;
    int pick;
    pick = $urandom_range(0, 99);
    s = SLOT_W'($urandom_range(0, span - 1));
    smp = '0;
    if ($urandom_range(0, 15) == 0) step = rand63() >> $urandom_range(8, 40);
    else step = TIME_W'($urandom_range(1, 5000));
    now_ns = now_ns + step;
    ts = now_ns;
    if (pick < 35) begin
      m = MODE_START;
    end else if (pick < 70) begin
      m = MODE_STOP;
    end else if (pick < 88) begin
      m = MODE_ADD;
      if ($urandom_range(0, 9) == 0) smp = {1'b0, rand63()};
      else smp = SMP_W'($urandom_range(0, 100000));
    end else begin
      // noise: any mode, any slot, arbitrary stamp and sample
      m = MODE_W'($urandom_range(0, 3));
      s = SLOT_W'($urandom_range(0, 63));
      ts = rand63();
      smp = {$urandom, $urandom};
    end
    send_req(m, s, ts, smp);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_active(input logic [CFG_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ACTIVE_ADDR;
    cfg_pwdata  <= {{(32-CFG_W){1'b0}}, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    // read back
    cfg_psel    <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    settings_cnt++;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] active, input int n, input int span);
    write_active(active);
    repeat (n) random_req(span);
    drain_results();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    sent_cnt    = 0;
    settings_cnt = 0;
    idle_on     = 1'b1;
    hold_off_req = 1'b0;
    now_ns      = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stop on a never started slot, then ties and a wrapped interval
    send_req(MODE_STOP, 6'd0, 63'd100, '0);
    send_req(MODE_START, 6'd1, 63'd1000, '0);
    send_req(MODE_STOP, 6'd1, 63'd1500, '0);
    send_req(MODE_STOP, 6'd1, 63'd1500, '0);
    send_req(MODE_START, 6'd2, TIME_MAX, '0);
    send_req(MODE_STOP, 6'd2, 63'd5, '0);
    // sum saturation and extreme samples
    send_req(MODE_ADD, 6'd3, '0, 64'd0);
    send_req(MODE_ADD, 6'd3, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_req(MODE_ADD, 6'd3, '0, 64'd1);
    send_req(MODE_ADD, 6'd4, '0, 64'h8000_0000_0000_0000);
    send_req(MODE_ADD, 6'd4, TIME_MAX, '1);
    send_req(MODE_NONE, 6'd3, '0, '0);
    send_req(MODE_NONE, 6'd5, TIME_MAX, '1);
    send_req(MODE_START, 6'd63, '0, '0);
    send_req(MODE_STOP, 6'd63, TIME_MAX, '0);
    send_req(MODE_ADD, 6'd63, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_req(MODE_START, 6'd42, rand63(), '0);
    send_req(MODE_STOP, 6'd42, rand63(), '0);
    drain_results();

    write_active(7'd1);
    send_req(MODE_ADD, 6'd0, '0, 64'd7);
    send_req(MODE_START, 6'd1, 63'd20, '0);
    send_req(MODE_STOP, 6'd63, 63'd30, '0);
    drain_results();
    write_active(7'd0);
    send_req(MODE_START, 6'd0, 63'd40, '0);
    drain_results();
    write_active(7'd127);
    send_req(MODE_STOP, 6'd63, 63'd10, '0);
    drain_results();

    random_phase(7'd1, 40, 2);
    random_phase(7'd0, 10, 64);
    random_phase(7'd127, 100, 64);
    random_phase(7'd17, 120, 20);

    // receiver stalls for a long stretch while requests keep coming
    write_active(7'd64);
    hold_off_req = 1'b1;
    repeat (30) random_req(8);
    repeat (240) random_req(8);
    idle_on = 1'b0;
    repeat (60) random_req(8);
    drain_results();
    repeat (80) @(posedge clk);

    $display("%0d requests sent, %0d results checked", sent_cnt, results_seen);
    $display("%0d active_slots settings written and read back, down to 0 and up to 127",
             settings_cnt);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("slot_interval_statistics_unit_tb passed");
    end else begin
      $display("slot_interval_statistics_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sit_pkg.sv
rtl/sit_div.sv
rtl/slot_interval_statistics_unit.sv
verif/sit_stats_checker.sv
verif/slot_interval_statistics_unit_tb.sv
